[rtl/core/rd_pkg.sv]
`default_nettype none

package rd_pkg;

  // operation codes carried in the slave tuser
  localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
  localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [1:0] OP_POP_BACK   = 2'd2;
  localparam logic [1:0] OP_POP_FRONT  = 2'd3;

  // status codes carried in the master tuser
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_DENIED = 2'd3;

  localparam int DATA_W = 32;
  localparam int FILL_W = 4;

  // controller to datapath
  typedef struct packed {
    logic exec;      // run the accepted operation on pointers and store
    logic load_out;  // move the finished result into the output register
  } rd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;  // output register holds a beat that is not taken this cycle
  } rd_stat_t;

endpackage

`default_nettype wire

[rtl/core/restricted_deque_top.sv]
// restricted_deque_top: bounded double-ended queue of DEPTH signed 32-bit entries
// with a one-bit restriction mode (0 inserts at back only, 1 deletes at front only).
// slave stream: one beat per operation, tuser the operation code, tdata the value
// to insert (ignored on pops). master stream: one beat per operation with the
// popped value and fill count in tdata and the status code in tuser.
// the mode register is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce.
// the pointer update and the registered read of the entry store happen at the
// edge that accepts an operation; the result is loaded into the output register
// once it is free. a new operation is not taken until the last result is loaded,
// by the accept/finish sequence of the controller around the single store port.
// the next operation is accepted while a finished result waits in the output
// register; if the receiver stalls longer, tready stays low until it is free.
// reset clears pointers, count, mode and the output valid; stored entries are
// not cleared and no clearing pass runs.
`default_nettype none

module restricted_deque_top #(
  parameter int DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,       // restriction_mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,    // [31:0] push_value
  input  wire logic [1:0]  s_axis_tuser,    // [1:0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,    // [31:0] popped_value, [35:32] fill_count
  output logic [1:0]       m_axis_tuser     // [1:0] status
);
  import rd_pkg::*;

  rd_cmd_t  cmd;
  rd_stat_t stat;

  logic [DATA_W-1:0] out_value;
  logic [FILL_W-1:0] out_fill;

  // sequencing of accept and result load
  rd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // pointers, store and result register
  rd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .op_in      (s_axis_tuser),
    .value_in   (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (out_value),
    .out_status (m_axis_tuser),
    .out_fill   (out_fill)
  );

  // pack the result beat
  assign m_axis_tdata = {4'b0000, out_fill, out_value};

endmodule

`default_nettype wire

[rtl/core/rd_ctrl.sv]
`default_nettype none

module rd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output rd_pkg::rd_cmd_t      cmd,
  input  wire rd_pkg::rd_stat_t stat
);
  import rd_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // accept in idle, finish once the output register is free
  always_comb begin
    state_next   = state;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rd_dp.sv]
`default_nettype none

module rd_dp #(
  parameter int DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_wdata,
  input  wire logic [1:0]                  op_in,
  input  wire logic [rd_pkg::DATA_W-1:0]   value_in,
  input  wire rd_pkg::rd_cmd_t             cmd,
  output rd_pkg::rd_stat_t                 stat,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rd_pkg::DATA_W-1:0]        out_value,
  output logic [1:0]                       out_status,
  output logic [rd_pkg::FILL_W-1:0]        out_fill
);
  import rd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  logic [AW-1:0] head_pointer;
  logic [AW-1:0] tail_pointer;
  logic [CW-1:0] entry_count;
  logic          mode;

  logic [1:0]    res_status;
  logic          res_pop;

  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] tail_dec;
  logic          is_push;
  logic [1:0]    status_now;
  logic          do_op;
  logic [CW+FILL_W-1:0] fill_ext;

  // circular pointer neighbors
  always_comb begin
    head_inc = (head_pointer == LAST_SLOT) ? '0 : head_pointer + AW'(1);
    head_dec = (head_pointer == '0) ? LAST_SLOT : head_pointer - AW'(1);
    tail_inc = (tail_pointer == LAST_SLOT) ? '0 : tail_pointer + AW'(1);
    tail_dec = (tail_pointer == '0) ? LAST_SLOT : tail_pointer - AW'(1);
  end

  // mode check first, then full or empty
  always_comb begin
    is_push = (op_in == OP_PUSH_BACK) || (op_in == OP_PUSH_FRONT);
    if ((op_in == OP_PUSH_FRONT && !mode) || (op_in == OP_POP_BACK && mode)) begin
      status_now = ST_DENIED;
    end else if (is_push && entry_count == FULL_CNT) begin
      status_now = ST_FULL;
    end else if (!is_push && entry_count == '0) begin
      status_now = ST_EMPTY;
    end else begin
      status_now = ST_OK;
    end
    do_op = cmd.exec && (status_now == ST_OK);
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head_pointer <= '0;
      tail_pointer <= '0;
      entry_count  <= '0;
    end else if (do_op) begin
      case (op_in)
        OP_PUSH_BACK: begin
          tail_pointer <= tail_inc;
          entry_count  <= entry_count + CW'(1);
        end
        OP_PUSH_FRONT: begin
          head_pointer <= head_dec;
          entry_count  <= entry_count + CW'(1);
        end
        OP_POP_BACK: begin
          tail_pointer <= tail_dec;
          entry_count  <= entry_count - CW'(1);
        end
        default: begin
          head_pointer <= head_inc;
          entry_count  <= entry_count - CW'(1);
        end
      endcase
    end
  end

  // entry store: one write or one registered read per operation
  always_ff @(posedge clk) begin
    if (do_op) begin
      case (op_in)
        OP_PUSH_BACK:  mem[tail_pointer] <= value_in;
        OP_PUSH_FRONT: mem[head_dec] <= value_in;
        OP_POP_BACK:   rdata <= mem[tail_dec];
        default:       rdata <= mem[head_pointer];
      endcase
    end
  end

  // per-operation result bits
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_now;
      res_pop    <= !is_push;
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, entry_count};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value  <= (res_pop && res_status == ST_OK) ? rdata : '0;
      out_status <= res_status;
      out_fill   <= fill_ext[FILL_W-1:0];
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rd_pkg::*;

  localparam int DEPTH       = 8;
  localparam int SETTLE      = 4;     // result latency plus margin
  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
  localparam int HOLD_LEN    = 160;   // long receiver stall
  localparam int PRINT_CAP   = 100;

  // one predicted result beat
  typedef struct packed {
    logic [31:0] popped;
    logic [1:0]  status;
    logic [3:0]  fill;
  } deque_outcome_t;

  // deque predictor and result checker
  class deque_scoreboard;
    deque_outcome_t outcomes[$];
    logic [31:0]    slots[DEPTH];
    int unsigned    head;
    int unsigned    tail;
    int unsigned    count;
    logic           mode;
    int             mismatches;
    int             beats_seen;

    function new();
      head = 0;
      tail = 0;
      count = 0;
      mode = 1'b0;
      mismatches = 0;
      beats_seen = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function int pending();
      return outcomes.size();
    endfunction

    // run one accepted operation on the local copy and queue its result
    function void note_operation(logic [1:0] op, logic [31:0] value);
      deque_outcome_t res;
      logic is_push;
      res.popped = '0;
      res.status = ST_OK;
      is_push = (op == OP_PUSH_BACK) || (op == OP_PUSH_FRONT);
      // mode restriction wins over full and empty
      if ((op == OP_PUSH_FRONT && mode == 1'b0) || (op == OP_POP_BACK && mode == 1'b1)) begin
        res.status = ST_DENIED;
      end else if (is_push && count == DEPTH) begin
        res.status = ST_FULL;
      end else if (!is_push && count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        case (op)
          OP_PUSH_BACK: begin
            slots[tail] = value;
            tail = (tail + 1) % DEPTH;
            count++;
          end
          OP_PUSH_FRONT: begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = value;
            count++;
          end
          OP_POP_BACK: begin
            tail = (tail + DEPTH - 1) % DEPTH;
            res.popped = slots[tail];
            count--;
          end
          default: begin
            res.popped = slots[head];
            head = (head + 1) % DEPTH;
            count--;
          end
        endcase
      end
      res.fill = count[3:0];
      outcomes.push_back(res);
    endfunction

    task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
      if (mismatches < PRINT_CAP)
        $display("%0t: beat %0d %s: got %h, expected %h", $time, beats_seen, field, got, want);
      mismatches++;
    endtask

    // compare a result beat against the oldest prediction
    task check_outcome(input logic [39:0] data, input logic [1:0] user);
      deque_outcome_t want;
      beats_seen++;
      if (outcomes.size() == 0) begin
        report_mismatch("result with nothing outstanding", data[31:0], '0);
      end else begin
        want = outcomes.pop_front();
        if (data[31:0] !== want.popped)
          report_mismatch("popped_value", data[31:0], want.popped);
        if (user !== want.status)
          report_mismatch("status", 32'(user), 32'(want.status));
        if (data[35:32] !== want.fill)
          report_mismatch("fill_count", 32'(data[35:32]), 32'(want.fill));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_PUSH_BACK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  deque_scoreboard sb = new();

  int   send_idle_pct = 27;
  int   recv_idle_pct = 76;
  int   hold_len_req = 0;
  logic mode_now = 1'b0;

  restricted_deque_top #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // beat monitor on both sides, results first
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_outcome(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_operation(s_axis_tuser, s_axis_tdata);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    forever begin
      @(posedge clk);
      if (hold_len_req != 0) begin
        stall_left = hold_len_req;
        hold_len_req = 0;
        while (stall_left != 0) begin
          m_axis_tready <= 1'b0;
          @(posedge clk);
          stall_left--;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one operation beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [1:0] op, input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_queue();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mode register write, only with the block idle
  task automatic write_mode(input logic m);
    drain_queue();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
    mode_now = m;
  endtask

  // random operations, mostly legal for the mode, with push/pop bias
  // changing every 16 beats so the deque swings between full and empty
  task automatic run_random(input int n);
    int push_pct;
    logic [1:0] op;
    logic [31:0] value;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      if ($urandom_range(99) < 8)
        op = 2'($urandom_range(3));
      else if ($urandom_range(99) < push_pct)
        op = (mode_now && $urandom_range(1)) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else
        op = (!mode_now && $urandom_range(1)) ? OP_POP_BACK : OP_POP_FRONT;
      case ($urandom_range(11))
        0:       value = 32'h7fff_ffff;
        1:       value = 32'h8000_0000;
        2:       value = 32'hffff_ffff;
        3:       value = 32'h0000_0000;
        default: value = $urandom;
      endcase
      send_beat(op, value);
    end
  endtask

  // main sequence
  initial begin
    logic [31:0] extreme_vals[8];
    extreme_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                     32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555, 32'h1234_5678};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // input-restricted mode out of reset: empty pops, fill to full, denial
    send_beat(OP_POP_BACK, 32'h0);
    send_beat(OP_POP_FRONT, 32'h0);
    for (int i = 0; i < 8; i++)
      send_beat(OP_PUSH_BACK, extreme_vals[i]);
    send_beat(OP_PUSH_BACK, 32'hdead_beef);
    send_beat(OP_PUSH_FRONT, 32'h0bad_0bad);
    send_beat(OP_POP_BACK, 32'hffff_ffff);
    send_beat(OP_POP_FRONT, 32'h0);

    // output-restricted mode: back pop denied, front pushes to full
    write_mode(1'b1);
    send_beat(OP_POP_BACK, 32'h0);
    send_beat(OP_PUSH_FRONT, 32'h8000_0001);
    send_beat(OP_PUSH_FRONT, 32'h7fff_fffe);
    send_beat(OP_PUSH_FRONT, 32'hcafe_f00d);
    send_beat(OP_PUSH_BACK, 32'hface_b00c);
    send_beat(OP_POP_FRONT, 32'h0);
    send_beat(OP_POP_FRONT, 32'h0);

    // random part in three idling profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 8; blk++) begin
        write_mode((blk < 2) ? blk[0] : 1'($urandom_range(1)));
        // long receiver stall while beats keep coming
        if (blk == 3)
          hold_len_req = HOLD_LEN;
        run_random(33);
        if (blk == 5)
          drain_queue();
        run_random(33);
      end
    end

    drain_queue();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
